// ----- rtl/xcr_pkg.sv -----
// Shared constants for the XMODEM checksum receiver.
// Control characters, phase codes, result event codes, item kinds and configuration.
// No dependencies.
package xcr_pkg;

  // serial control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_PAD = 8'h1A;
  localparam logic [7:0] CH_ALL_ONES = 8'hFF;

  // receive phases
  localparam logic [2:0] PH_AWAIT = 3'd0;
  localparam logic [2:0] PH_NUM   = 3'd1;
  localparam logic [2:0] PH_COMP  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SUM   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // result events
  localparam logic [1:0] EV_STORE = 2'd0;
  localparam logic [1:0] EV_REPLY = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ABORT = 2'd3;

  // item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration
  localparam int unsigned NAK_W = 21;
  localparam logic [NAK_W-1:0] NAK_INTERVAL_RST = 21'd2000000;
  localparam logic REG_NAK_INTERVAL = 1'b0;

endpackage

// ----- rtl/xmodem_checksum_receiver.sv -----
// XMODEM receiver, 8-bit additive checksum, one byte or tick per word.
// Frame checking, buffer write generation, reply and completion events.
// Depends on xcr_pkg.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+--------------------------------
//  in       | in  | in_valid_i / in_ready_o   | cmd_i, rx_byte_i
//  out      | out | out_valid_o / out_ready_i | event_res_o, tx_byte_o,
//           |     |                           | store_addr_o, store_data_o,
//           |     |                           | final_length_o
//  cfg      | in  | APB psel/penable/pready   | nak_interval at byte address 0
//
// One word accepted per cycle while in_ready_o is high; its result (if any) sits in the
// output register in the cycle after acceptance.
// in_ready_o drops only while a result is held and out_ready_i is low.
// Async active-low reset returns to awaiting a command byte, block 1,
// nak_interval = 2000000. After completion or abort all words are
// swallowed until reset.
module xmodem_checksum_receiver #(
  parameter int unsigned BLOCK_BYTES = 128,
  parameter int unsigned ADDR_WIDTH  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [7:0]            rx_byte_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            event_res_o,
  output logic [7:0]            tx_byte_o,
  output logic [ADDR_WIDTH-1:0] store_addr_o,
  output logic [7:0]            store_data_o,
  output logic [ADDR_WIDTH-1:0] final_length_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import xcr_pkg::*;

  localparam int unsigned AW   = ADDR_WIDTH;
  localparam int unsigned IDXW = $clog2(BLOCK_BYTES + 1);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(BLOCK_BYTES - 1);
  localparam logic [IDXW-1:0] BLK_CNT   = IDXW'(BLOCK_BYTES);
  localparam logic [AW:0]     BLK_LEN   = (AW+1)'(BLOCK_BYTES);
  localparam logic [AW+1:0]   BLK_LEN_X = (AW+2)'(BLOCK_BYTES);
  localparam logic [AW+1:0]   ADDR_SPAN = (AW+2)'(1) << AW;
  localparam logic [AW:0]     MIN_TRIM  = (AW+1)'(3);

  // ---------------------------------------------------------------- config
  logic [NAK_W-1:0] nak_interval_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NAK_INTERVAL);
  assign prdata = (paddr[2] == REG_NAK_INTERVAL) ? {{(32-NAK_W){1'b0}}, nak_interval_q}
                                                  : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nak_interval_q <= NAK_INTERVAL_RST;
    end else if (cfg_wr) begin
      nak_interval_q <= pwdata[NAK_W-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  logic [2:0]       phase_q, phase_d;
  logic [7:0]       exp_block_q, exp_block_d;
  logic             hdr_bad_q, hdr_bad_d;
  logic [7:0]       cap_num_q, cap_num_d;
  logic [IDXW-1:0]  byte_idx_q, byte_idx_d;
  logic [7:0]       run_sum_q, run_sum_d;
  logic [AW:0]      commit_len_q, commit_len_d;
  logic             started_q, started_d;
  logic [NAK_W-1:0] idle_ticks_q, idle_ticks_d;
  logic [AW:0]      tail_pad_q, tail_pad_d;
  logic [IDXW-1:0]  blk_pad_q, blk_pad_d;

  logic             in_fire;
  logic             out_valid_q;

  // next result
  logic             res_vld;
  logic [1:0]       res_ev;
  logic [7:0]       res_tx;
  logic [AW-1:0]    res_addr;
  logic [7:0]       res_data;
  logic [AW-1:0]    res_len;

  // datapath helpers
  logic [NAK_W-1:0] ticks_inc;
  logic [AW:0]      addr_sum;
  logic [AW:0]      trim;
  logic [AW:0]      len_full;
  logic [AW+1:0]    next_end;
  logic [7:0]       sum_next;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ticks_inc = idle_ticks_q + NAK_W'(1);
  assign addr_sum  = commit_len_q + (AW+1)'(byte_idx_q);
  assign next_end  = {1'b0, commit_len_q} + BLK_LEN_X;
  assign sum_next  = run_sum_q + rx_byte_i;

  always_comb begin
    trim = (tail_pad_q >= MIN_TRIM) ? tail_pad_q : '0;
    if (trim > commit_len_q) begin
      trim = commit_len_q;
    end
    len_full = commit_len_q - trim;
  end

  always_comb begin
    phase_d      = phase_q;
    exp_block_d  = exp_block_q;
    hdr_bad_d    = hdr_bad_q;
    cap_num_d    = cap_num_q;
    byte_idx_d   = byte_idx_q;
    run_sum_d    = run_sum_q;
    commit_len_d = commit_len_q;
    started_d    = started_q;
    idle_ticks_d = idle_ticks_q;
    tail_pad_d   = tail_pad_q;
    blk_pad_d    = blk_pad_q;
    res_vld      = 1'b0;
    res_ev       = EV_STORE;
    res_tx       = 8'd0;
    res_addr     = '0;
    res_data     = 8'd0;
    res_len      = '0;

    if (in_fire && (phase_q != PH_DONE)) begin
      if (cmd_i == CMD_TICK) begin
        // ticks only matter while waiting for the sender's first block
        if ((phase_q == PH_AWAIT) && !started_q) begin
          if (ticks_inc >= nak_interval_q) begin
            idle_ticks_d = '0;
            res_vld      = 1'b1;
            res_ev       = EV_REPLY;
            res_tx       = CH_NAK;
          end else begin
            idle_ticks_d = ticks_inc;
          end
        end
      end else begin
        case (phase_q)
          PH_AWAIT: begin
            idle_ticks_d = '0;
            if (rx_byte_i == CH_EOT) begin
              phase_d = PH_DONE;
              res_vld = 1'b1;
              res_ev  = EV_DONE;
              res_tx  = CH_ACK;
              res_len = len_full[AW-1:0];
            end else if (rx_byte_i == CH_CAN) begin
              phase_d = PH_DONE;
              res_vld = 1'b1;
              res_ev  = EV_ABORT;
            end else if (rx_byte_i == CH_SOH) begin
              started_d = 1'b1;
              if (next_end > ADDR_SPAN) begin
                phase_d = PH_DONE;
                res_vld = 1'b1;
                res_ev  = EV_ABORT;
              end else begin
                phase_d = PH_NUM;
              end
            end else if (started_q) begin
              phase_d = PH_DONE;
              res_vld = 1'b1;
              res_ev  = EV_ABORT;
            end
          end
          PH_NUM: begin
            cap_num_d = rx_byte_i;
            hdr_bad_d = (rx_byte_i != exp_block_q);
            phase_d   = PH_COMP;
          end
          PH_COMP: begin
            if ((cap_num_q ^ rx_byte_i) != CH_ALL_ONES) begin
              hdr_bad_d = 1'b1;
            end
            byte_idx_d = '0;
            run_sum_d  = 8'd0;
            blk_pad_d  = '0;
            phase_d    = PH_DATA;
          end
          PH_DATA: begin
            run_sum_d  = sum_next;
            blk_pad_d  = (rx_byte_i == CH_PAD) ? blk_pad_q + IDXW'(1) : '0;
            byte_idx_d = byte_idx_q + IDXW'(1);
            if (byte_idx_q == LAST_IDX) begin
              phase_d = PH_SUM;
            end
            res_vld  = 1'b1;
            res_ev   = EV_STORE;
            res_addr = addr_sum[AW-1:0];
            res_data = rx_byte_i;
          end
          PH_SUM: begin
            phase_d = PH_AWAIT;
            res_vld = 1'b1;
            res_ev  = EV_REPLY;
            if (hdr_bad_q || (run_sum_q != rx_byte_i)) begin
              res_tx = CH_NAK;
            end else begin
              res_tx       = CH_ACK;
              exp_block_d  = exp_block_q + 8'd1;
              commit_len_d = commit_len_q + BLK_LEN;
              // an all-pad block extends the trailing run, else the run restarts
              if (blk_pad_q >= BLK_CNT) begin
                tail_pad_d = tail_pad_q + BLK_LEN;
              end else begin
                tail_pad_d = (AW+1)'(blk_pad_q);
              end
            end
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_AWAIT;
      exp_block_q  <= 8'd1;
      hdr_bad_q    <= 1'b0;
      cap_num_q    <= 8'd0;
      byte_idx_q   <= '0;
      run_sum_q    <= 8'd0;
      commit_len_q <= '0;
      started_q    <= 1'b0;
      idle_ticks_q <= '0;
      tail_pad_q   <= '0;
      blk_pad_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      exp_block_q  <= exp_block_d;
      hdr_bad_q    <= hdr_bad_d;
      cap_num_q    <= cap_num_d;
      byte_idx_q   <= byte_idx_d;
      run_sum_q    <= run_sum_d;
      commit_len_q <= commit_len_d;
      started_q    <= started_d;
      idle_ticks_q <= idle_ticks_d;
      tail_pad_q   <= tail_pad_d;
      blk_pad_q    <= blk_pad_d;
    end
  end

  // ---------------------------------------------------------------- output register
  logic           out_valid_d;
  logic [1:0]     ev_q;
  logic [7:0]     tx_q;
  logic [AW-1:0]  addr_q;
  logic [7:0]     data_q;
  logic [AW-1:0]  len_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res_vld;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_vld) begin
      ev_q   <= res_ev;
      tx_q   <= res_tx;
      addr_q <= res_addr;
      data_q <= res_data;
      len_q  <= res_len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign tx_byte_o      = tx_q;
  assign store_addr_o   = addr_q;
  assign store_data_o   = data_q;
  assign final_length_o = len_q;

  // ---------------------------------------------------------------- checks
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE))
    else $error("receiver left the finished phase");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (byte_idx_q < BLK_CNT))
    else $error("payload index past block end");

  a_sum_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == CMD_BYTE) && (phase_q == PH_SUM))
      |=> (out_valid_o && (event_res_o == EV_REPLY)
           && ((tx_byte_o == CH_ACK) || (tx_byte_o == CH_NAK))))
    else $error("checksum word gave no ACK/NAK reply");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for xmodem_checksum_receiver.
// Sends NAK pacing ticks, block frames (good and corrupted) and one end of transfer,
// and checks every result word against a built-in receiver model. Depends on xcr_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import xcr_pkg::*;

  localparam int BLOCK_LEN = 128;
  localparam int ADDR_W = 24;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [2:0] NAK_ADDR = {REG_NAK_INTERVAL, 2'b00};

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        tx;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [ADDR_W-1:0] len;
  } rx_result_t;

  typedef enum int {
    FR_GOOD, FR_EXTREME, FR_BAD_NUM, FR_BAD_COMP, FR_BAD_SUM, FR_REPEAT, FR_PAD_TAIL,
    FR_ALL_PAD
  } frame_kind_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              cmd_i;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        event_res_o;
  logic [7:0]        tx_byte_o;
  logic [ADDR_W-1:0] store_addr_o;
  logic [7:0]        store_data_o;
  logic [ADDR_W-1:0] final_length_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  xmodem_checksum_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .tx_byte_o     (tx_byte_o),
    .store_addr_o  (store_addr_o),
    .store_data_o  (store_data_o),
    .final_length_o(final_length_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // receiver model state
  logic [2:0]        rx_phase;
  logic [7:0]        want_block;
  bit                header_bad;
  logic [7:0]        got_number;
  int                data_count;
  logic [7:0]        sum_acc;
  longint unsigned   saved_len;
  bit                started;
  logic [20:0]       idle_ticks;
  longint unsigned   tail_pad;
  int                block_pad;
  logic [20:0]       nak_ticks;

  rx_result_t        pending_replies[$];
  int                errors;
  int                words_sent;
  int                cycles;
  bit                gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[xmodem_checksum_receiver] ERROR");
      $finish;
    end
  end

  // expected result for one accepted word
  task automatic predict_reply(input logic cmd, input logic [7:0] b);
    rx_result_t r;
    bit has;
    longint unsigned trim;
    r = '0;
    has = 1'b0;
    trim = 0;
    if (rx_phase != PH_DONE) begin
      if (cmd == CMD_TICK) begin
        if (rx_phase == PH_AWAIT && !started) begin
          idle_ticks = idle_ticks + 21'd1;
          if (idle_ticks >= nak_ticks) begin
            idle_ticks = '0;
            r.kind = EV_REPLY;
            r.tx = CH_NAK;
            has = 1'b1;
          end
        end
      end else begin
        case (rx_phase)
          PH_AWAIT: begin
            idle_ticks = '0;
            if (b == CH_EOT) begin
              if (tail_pad >= 3) trim = tail_pad;
              if (trim > saved_len) trim = saved_len;
              rx_phase = PH_DONE;
              r.kind = EV_DONE;
              r.tx = CH_ACK;
              r.len = ADDR_W'(saved_len - trim);
              has = 1'b1;
            end else if (b == CH_CAN) begin
              rx_phase = PH_DONE;
              r.kind = EV_ABORT;
              has = 1'b1;
            end else if (b == CH_SOH) begin
              started = 1'b1;
              if (saved_len + BLOCK_LEN > (64'd1 << ADDR_W)) begin
                rx_phase = PH_DONE;
                r.kind = EV_ABORT;
                has = 1'b1;
              end else begin
                rx_phase = PH_NUM;
              end
            end else if (started) begin
              // stray byte between frames
              rx_phase = PH_DONE;
              r.kind = EV_ABORT;
              has = 1'b1;
            end
          end
          PH_NUM: begin
            got_number = b;
            header_bad = (b != want_block);
            rx_phase = PH_COMP;
          end
          PH_COMP: begin
            if ((got_number ^ b) != CH_ALL_ONES) header_bad = 1'b1;
            data_count = 0;
            sum_acc = '0;
            block_pad = 0;
            rx_phase = PH_DATA;
          end
          PH_DATA: begin
            r.kind = EV_STORE;
            r.addr = ADDR_W'(saved_len + data_count);
            r.data = b;
            has = 1'b1;
            sum_acc = sum_acc + b;
            block_pad = (b == CH_PAD) ? block_pad + 1 : 0;
            data_count++;
            if (data_count >= BLOCK_LEN) rx_phase = PH_SUM;
          end
          PH_SUM: begin
            rx_phase = PH_AWAIT;
            r.kind = EV_REPLY;
            has = 1'b1;
            if (header_bad || sum_acc != b) begin
              r.tx = CH_NAK;
            end else begin
              r.tx = CH_ACK;
              want_block = want_block + 8'd1;
              saved_len += BLOCK_LEN;
              if (block_pad >= BLOCK_LEN) tail_pad += BLOCK_LEN;
              else tail_pad = block_pad;
            end
          end
          default: rx_phase = PH_DONE;
        endcase
      end
    end
    if (has) pending_replies.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    rx_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result word, event %0h tx %0h addr %0h data %0h len %0h",
                 $time, event_res_o, tx_byte_o, store_addr_o, store_data_o, final_length_o);
        errors++;
      end else begin
        w = pending_replies.pop_front();
        check_field("event_res", w.kind, event_res_o);
        check_field("tx_byte", w.tx, tx_byte_o);
        check_field("store_addr", w.addr, store_addr_o);
        check_field("store_data", w.data, store_data_o);
        check_field("final_length", w.len, final_length_o);
      end
    end
  end

  // result side back-pressure, with quiet stretches
  initial begin
    int hold;
    int span;
    int r;
    bit quiet;
    hold = 0;
    span = 0;
    quiet = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        span = 100;
        quiet = ($urandom_range(0, 2) == 0);
      end
      span--;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
        end else if (r < 94) begin
          hold = $urandom_range(0, 2);
          out_ready_i <= 1'b0;
        end else begin
          hold = $urandom_range(8, 40);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_stray();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
    return b;
  endfunction

  // one input word; valid stays high across back-to-back words
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reply(cmd, b);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 8'($urandom));
  endtask

  task automatic send_rx(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    send_word(CMD_BYTE, b);
  endtask

  // let results drain and the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] a, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [2:0] a, input logic [31:0] v);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    check_field("prdata", v, got);
  endtask

  task automatic set_nak_interval(input logic [20:0] v);
    wait_idle();
    apb_write(NAK_ADDR, 32'(v));
    nak_ticks = v;
    apb_read_check(NAK_ADDR, 32'(v));
  endtask

  task automatic send_frame(input frame_kind_e kind, input int tick_pct);
    logic [7:0] body[BLOCK_LEN];
    logic [7:0] num;
    logic [7:0] comp;
    logic [7:0] sum;
    int pad_len;
    num = want_block;
    sum = '0;
    pad_len = (kind == FR_PAD_TAIL) ? $urandom_range(1, 10) : 0;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      if (kind == FR_EXTREME) body[i] = i[0] ? 8'hFF : 8'h00;
      else if (kind == FR_ALL_PAD || i >= BLOCK_LEN - pad_len || $urandom_range(0, 7) == 0)
        body[i] = CH_PAD;
      else body[i] = 8'($urandom);
      sum = sum + body[i];
    end
    if (kind == FR_BAD_NUM) num = num ^ 8'($urandom_range(1, 255));
    if (kind == FR_REPEAT) num = want_block - 8'd1;
    comp = ~num;
    if (kind == FR_BAD_COMP) comp = comp ^ 8'($urandom_range(1, 255));
    if (kind == FR_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    gaps_on = ($urandom_range(0, 3) != 0);
    send_rx(CH_SOH, tick_pct);
    send_rx(num, tick_pct);
    send_rx(comp, tick_pct);
    for (int i = 0; i < BLOCK_LEN; i++) send_rx(body[i], tick_pct);
    send_rx(sum, tick_pct);
  endtask

  // NAK pacing before the first block, across interval settings
  task automatic test_nak_pacing();
    apb_read_check(NAK_ADDR, 32'(NAK_INTERVAL_RST));
    repeat (4) send_tick();
    set_nak_interval(21'd1);
    repeat (3) send_tick();
    set_nak_interval(21'd0);
    repeat (3) send_tick();
    set_nak_interval(21'h1FFFFF);
    repeat (2) send_tick();
    send_word(CMD_BYTE, 8'h00);
    send_tick();
    set_nak_interval(21'd3);
    repeat (2) send_tick();
    send_word(CMD_BYTE, 8'hFF);
    repeat (4) send_tick();
    send_word(CMD_BYTE, CH_ACK);
    repeat (3) send_tick();
    send_word(CMD_BYTE, CH_PAD);
    send_word(CMD_BYTE, CH_NAK);
    set_nak_interval(21'($urandom_range(2, 9)));
    repeat (12) begin
      if ($urandom_range(0, 3) == 0) send_word(CMD_BYTE, pick_stray());
      else send_tick();
    end
  endtask

  // every frame kind once, in random order, after the all-extremes block
  task automatic test_frame_kinds();
    frame_kind_e tour[$];
    int k;
    tour = '{FR_GOOD, FR_BAD_NUM, FR_BAD_COMP, FR_BAD_SUM, FR_REPEAT, FR_PAD_TAIL,
             FR_ALL_PAD};
    send_frame(FR_EXTREME, 10);
    while (tour.size() != 0) begin
      k = $urandom_range(0, tour.size() - 1);
      send_frame(tour[k], $urandom_range(0, 1) ? 0 : 10);
      tour.delete(k);
    end
  endtask

  // random frames until the whole run has sent about 1000 words
  task automatic test_random_frames();
    frame_kind_e kind;
    while (words_sent < 1000) begin
      if ($urandom_range(0, 99) < 65) kind = FR_GOOD;
      else kind = frame_kind_e'($urandom_range(FR_GOOD, FR_ALL_PAD));
      send_frame(kind, $urandom_range(0, 2) * 5);
    end
    // last committed data may end in padding
    send_frame(frame_kind_e'($urandom_range(0, 2) == 0 ? FR_GOOD :
               ($urandom_range(0, 1) ? FR_PAD_TAIL : FR_ALL_PAD)), 5);
  endtask

  // EOT, CAN or a stray byte ends the transfer; everything after is swallowed
  task automatic test_end_of_transfer();
    int pick;
    pick = $urandom_range(0, 3);
    repeat ($urandom_range(0, 3)) send_tick();
    if (pick < 2) send_word(CMD_BYTE, CH_EOT);
    else if (pick == 2) send_word(CMD_BYTE, CH_CAN);
    else send_word(CMD_BYTE, pick_stray());
    send_word(CMD_BYTE, CH_SOH);
    send_word(CMD_BYTE, CH_EOT);
    repeat (15) begin
      if ($urandom_range(0, 1)) send_tick();
      else send_word(CMD_BYTE, 8'($urandom));
    end
  endtask

  initial begin
    rx_phase = PH_AWAIT;
    want_block = 8'd1;
    header_bad = 1'b0;
    got_number = '0;
    data_count = 0;
    sum_acc = '0;
    saved_len = 0;
    started = 1'b0;
    idle_ticks = '0;
    tail_pad = 0;
    block_pad = 0;
    nak_ticks = NAK_INTERVAL_RST;
    errors = 0;
    words_sent = 0;
    gaps_on = 1'b1;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_BYTE;
    rx_byte_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_nak_pacing();
    test_frame_kinds();
    test_random_frames();
    test_end_of_transfer();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("[xmodem_checksum_receiver] OK");
    end else begin
      $display("[xmodem_checksum_receiver] ERROR");
    end
    $finish;
  end

endmodule
